// ===== hdl/itda_pkg.sv =====
// ----------------------------------------------------------------------------
// itda_pkg
// Shared constants for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

  // output character width and codes
  localparam int unsigned CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

  // one decimal digit in bcd
  localparam int unsigned DIGIT_W = 4;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_THREE = 4'd3;

  // shift-and-add-3 steps done in one pipeline stage
  localparam int unsigned DABBLE_STEPS = 8;

endpackage

// ===== hdl/itda_neg.sv =====
// ----------------------------------------------------------------------------
// itda_neg
// Entry stage: splits the signed request into sign and magnitude.
// ----------------------------------------------------------------------------
module itda_neg
  import itda_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  output logic         in_rdy,
  input  logic [W-1:0] in_val,
  output logic         out_vld,
  input  logic         out_rdy,
  output logic         out_neg,
  output logic [W-1:0] out_mag
);

  logic         vld_r;
  logic         neg_r;
  logic [W-1:0] mag_r;
  logic         neg_nxt;
  logic [W-1:0] mag_nxt;

  // stage can take a request when empty or when downstream drains it
  assign in_rdy = !vld_r || out_rdy;

  // magnitude fits in W bits unsigned, also for the most negative value
  always_comb begin
    neg_nxt = in_val[W-1];
    mag_nxt = neg_nxt ? (~in_val + {{(W-1){1'b0}}, 1'b1}) : in_val;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_neg = neg_r;
  assign out_mag = mag_r;

endmodule

// ===== hdl/itda_dabble.sv =====
// ----------------------------------------------------------------------------
// itda_dabble
// One pipeline stage of binary to bcd conversion: STEPS shift-and-add-3 steps.
// ----------------------------------------------------------------------------
module itda_dabble
  import itda_pkg::*;
#(
  parameter int unsigned W     = 32,
  parameter int unsigned ND    = 10,
  parameter int unsigned STEPS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  output logic                  in_rdy,
  input  logic                  in_neg,
  input  logic [W-1:0]          in_bin,
  input  logic [ND*DIGIT_W-1:0] in_bcd,
  output logic                  out_vld,
  input  logic                  out_rdy,
  output logic                  out_neg,
  output logic [W-1:0]          out_bin,
  output logic [ND*DIGIT_W-1:0] out_bcd
);

  localparam int unsigned BCD_W = ND * DIGIT_W;

  logic                 vld_r;
  logic                 neg_r;
  logic [W-1:0]         bin_r;
  logic [BCD_W-1:0]     bcd_r;
  logic [W-1:0]         bin_nxt;
  logic [BCD_W-1:0]     bcd_nxt;
  logic [BCD_W+W-1:0]   work;

  assign in_rdy = !vld_r || out_rdy;

  // adjust digits of five or more, then shift in the next binary bit
  always_comb begin
    work = {in_bcd, in_bin};
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < ND; d++) begin
        if (work[W+d*DIGIT_W +: DIGIT_W] >= DIGIT_FIVE) begin
          work[W+d*DIGIT_W +: DIGIT_W] = work[W+d*DIGIT_W +: DIGIT_W] + DIGIT_THREE;
        end
      end
      work = work << 1;
    end
    bin_nxt = work[W-1:0];
    bcd_nxt = work[BCD_W+W-1:W];
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      neg_r <= in_neg;
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_neg = neg_r;
  assign out_bin = bin_r;
  assign out_bcd = bcd_r;

endmodule

// ===== hdl/itda_lead.sv =====
// ----------------------------------------------------------------------------
// itda_lead
// Finds the most significant nonzero digit so leading zeros are skipped.
// ----------------------------------------------------------------------------
module itda_lead
  import itda_pkg::*;
#(
  parameter int unsigned ND    = 10,
  parameter int unsigned IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  output logic                  in_rdy,
  input  logic                  in_neg,
  input  logic [ND*DIGIT_W-1:0] in_bcd,
  output logic                  out_vld,
  input  logic                  out_rdy,
  output logic                  out_neg,
  output logic [ND*DIGIT_W-1:0] out_bcd,
  output logic [IDX_W-1:0]      out_msd
);

  logic                  vld_r;
  logic                  neg_r;
  logic [ND*DIGIT_W-1:0] bcd_r;
  logic [IDX_W-1:0]      msd_r;
  logic [IDX_W-1:0]      msd_nxt;

  assign in_rdy = !vld_r || out_rdy;

  // highest nonzero digit wins; all zero leaves index 0 for a single '0'
  always_comb begin
    msd_nxt = '0;
    for (int d = 0; d < ND; d++) begin
      if (in_bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
        msd_nxt = IDX_W'(d);
      end
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      neg_r <= in_neg;
      bcd_r <= in_bcd;
      msd_r <= msd_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_neg = neg_r;
  assign out_bcd = bcd_r;
  assign out_msd = msd_r;

endmodule

// ===== hdl/itda_serial.sv =====
// ----------------------------------------------------------------------------
// itda_serial
// Emits the sign and digits of one number, one character per cycle.
// ----------------------------------------------------------------------------
module itda_serial
  import itda_pkg::*;
#(
  parameter int unsigned ND    = 10,
  parameter int unsigned IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  output logic                  in_rdy,
  input  logic                  in_neg,
  input  logic [ND*DIGIT_W-1:0] in_bcd,
  input  logic [IDX_W-1:0]      in_msd,
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_ascii_char,
  output logic                  out_last
);

  logic                  act_r;
  logic                  sign_r;
  logic [IDX_W-1:0]      idx_r;
  logic [ND*DIGIT_W-1:0] bcd_r;
  logic                  ovld_r;
  logic [CHAR_W-1:0]     char_r;
  logic                  last_r;
  logic                  fin;
  logic [DIGIT_W-1:0]    digit;
  logic [CHAR_W-1:0]     char_nxt;

  // the final character goes out this cycle, so the next number may load
  assign fin    = act_r && !sign_r && (idx_r == '0);
  assign in_rdy = !act_r || fin;

  assign digit    = bcd_r[{idx_r, 2'b00} +: DIGIT_W];
  assign char_nxt = sign_r ? CH_MINUS : (CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit});

  // character sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (in_rdy) begin
      act_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      sign_r <= in_neg;
      idx_r  <= in_msd;
      bcd_r  <= in_bcd;
    end else if (act_r) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= fin;
  end

  assign out_valid      = ovld_r;
  assign out_ascii_char = char_r;
  assign out_last       = last_r;

endmodule

// ===== hdl/int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; in_value
//   is a two's complement integer of VALUE_WIDTH bits.
//   Each request yields its characters on out_ascii_char, one per cycle with
//   out_valid high for that cycle: '-' first for negative values, then the
//   digits without leading zeros, out_last high on the final one. Zero gives
//   a single '0'. The most negative value converts exactly.
//   The first character passes the sign stage, one shift-and-add-3 stage per
//   8 input bits, the leading-digit stage, the sequencer and its output
//   register; the rest follow back to back. The pipeline takes a request
//   every cycle unless held by the character sequencer, which sends one
//   character per cycle and takes the next number only with the final
//   character of the current one, up to 11 characters at 32 bits.
//   busy rises when the pipeline is full and waits on the sequencer.
//   The receiver cannot stall: each character is on the ports for exactly one cycle.
//   Reset (rst_n low, synchronous) empties the pipeline and drops any
//   characters not yet sent.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii
  import itda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  output logic [CHAR_W-1:0]      out_ascii_char,
  output logic                   out_last
);

  localparam int unsigned ND     = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned IDX_W  = $clog2(ND);
  localparam int unsigned BCD_W  = ND * DIGIT_W;
  localparam int unsigned NS     = (VALUE_WIDTH + DABBLE_STEPS - 1) / DABBLE_STEPS;
  localparam int unsigned LAST_S = VALUE_WIDTH - DABBLE_STEPS * (NS - 1);

  logic                   neg_rdy;
  logic                   vld   [NS+1];
  logic                   rdy   [NS+1];
  logic                   neg   [NS+1];
  logic [VALUE_WIDTH-1:0] bin   [NS+1];
  logic [BCD_W-1:0]       bcd   [NS+1];
  logic                   ld_vld;
  logic                   ld_rdy;
  logic                   ld_neg;
  logic [BCD_W-1:0]       ld_bcd;
  logic [IDX_W-1:0]       ld_msd;

  assign busy = !neg_rdy;

  // sign and magnitude
  itda_neg #(
    .W (VALUE_WIDTH)
  ) u_neg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .in_rdy  (neg_rdy),
    .in_val  (in_value),
    .out_vld (vld[0]),
    .out_rdy (rdy[0]),
    .out_neg (neg[0]),
    .out_mag (bin[0])
  );

  assign bcd[0] = '0;

  // binary to bcd pipeline
  for (genvar k = 0; k < NS; k++) begin : g_dabble
    localparam int unsigned STEPS = (k == NS - 1) ? LAST_S : DABBLE_STEPS;
    itda_dabble #(
      .W     (VALUE_WIDTH),
      .ND    (ND),
      .STEPS (STEPS)
    ) u_dabble (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld[k]),
      .in_rdy  (rdy[k]),
      .in_neg  (neg[k]),
      .in_bin  (bin[k]),
      .in_bcd  (bcd[k]),
      .out_vld (vld[k+1]),
      .out_rdy (rdy[k+1]),
      .out_neg (neg[k+1]),
      .out_bin (bin[k+1]),
      .out_bcd (bcd[k+1])
    );
  end

  // leading digit search
  itda_lead #(
    .ND    (ND),
    .IDX_W (IDX_W)
  ) u_lead (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld[NS]),
    .in_rdy  (rdy[NS]),
    .in_neg  (neg[NS]),
    .in_bcd  (bcd[NS]),
    .out_vld (ld_vld),
    .out_rdy (ld_rdy),
    .out_neg (ld_neg),
    .out_bcd (ld_bcd),
    .out_msd (ld_msd)
  );

  // character sequencer and output register
  itda_serial #(
    .ND    (ND),
    .IDX_W (IDX_W)
  ) u_serial (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (ld_vld),
    .in_rdy         (ld_rdy),
    .in_neg         (ld_neg),
    .in_bcd         (ld_bcd),
    .in_msd         (ld_msd),
    .out_valid      (out_valid),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last)
  );

endmodule
